### hdl/tgd_pkg.sv
// Shared types, codes and the electrode classifier for the touch gesture block.
// No dependencies; every other file imports this package.
`default_nettype none

package tgd_pkg;

	localparam int TOUCH_W = 12;
	localparam int POLLS_W = 8;
	localparam int GESTURE_W = 2;
	localparam int COMBO_W = 3;

	localparam logic [POLLS_W-1:0] STABLE_POLLS_RESET = 8'd3;

	localparam int ELECTRODE_A = 0;
	localparam int ELECTRODE_B = 2;
	localparam int ELECTRODE_C = 4;

	typedef logic [COMBO_W-1:0] combo_t;
	typedef logic [GESTURE_W-1:0] gesture_t;

	localparam combo_t COMBO_NONE  = 3'd0;
	localparam combo_t COMBO_AB    = 3'd1;
	localparam combo_t COMBO_BC    = 3'd2;
	localparam combo_t COMBO_ALL   = 3'd3;
	localparam combo_t COMBO_OTHER = 3'd4;

	localparam gesture_t GEST_NONE   = 2'd0;
	localparam gesture_t GEST_TOGGLE = 2'd1;
	localparam gesture_t GEST_UP     = 2'd2;
	localparam gesture_t GEST_DOWN   = 2'd3;

	// Debounce status handed from the stability tracker to the phase machine.
	typedef struct packed {
		combo_t combo;
		logic   settled;
	} debounce_t;

	function automatic combo_t combo_of(input logic [TOUCH_W-1:0] bits);
		logic a;
		logic b;
		logic c;
		combo_t r;
		a = bits[ELECTRODE_A];
		b = bits[ELECTRODE_B];
		c = bits[ELECTRODE_C];
		if (a && b && c) begin
			r = COMBO_ALL;
		end else if (a && b) begin
			r = COMBO_AB;
		end else if (b && c) begin
			r = COMBO_BC;
		end else if (!a && !b && !c) begin
			r = COMBO_NONE;
		end else begin
			r = COMBO_OTHER;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hdl/tgd_ifs.sv
// Valid/ready channel interfaces for polls in and gestures out.
// Depends on tgd_pkg for the payload widths.
`default_nettype none

interface tgd_poll_if import tgd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [TOUCH_W-1:0] touched_bits;

	modport source (output valid, output touched_bits, input ready);
	modport sink   (input valid, input touched_bits, output ready);
endinterface

interface tgd_result_if import tgd_pkg::*; ();
	logic     valid;
	logic     ready;
	gesture_t gesture;

	modport source (output valid, output gesture, input ready);
	modport sink   (input valid, input gesture, output ready);
endinterface

`default_nettype wire

### hdl/tgd_debounce.sv
// Stability tracker: last combination and saturating repeat count.
// Depends on tgd_pkg.
`default_nettype none

module tgd_debounce import tgd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               advance,
	input  wire combo_t             combo,
	input  wire logic [POLLS_W-1:0] stable_polls,
	output debounce_t               status
);

	combo_t             prev_combo_q;
	logic [POLLS_W-1:0] count_q;
	logic [POLLS_W-1:0] count_next;

	always_comb begin
		if (combo == prev_combo_q) begin
			// saturate at the threshold; threshold fits in the count, so no wrap
			count_next = (count_q < stable_polls) ? count_q + 1'b1 : count_q;
		end else begin
			count_next = POLLS_W'(1);
		end
	end

	assign status.combo   = combo;
	assign status.settled = (count_next >= stable_polls);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_combo_q <= COMBO_NONE;
			count_q      <= '0;
		end else if (advance) begin
			prev_combo_q <= combo;
			count_q      <= count_next;
		end
	end

endmodule

`default_nettype wire

### hdl/tgd_phase_fsm.sv
// Gesture phase machine: idle, ramping up, ramping down, draining.
// Depends on tgd_pkg.
`default_nettype none

module tgd_phase_fsm import tgd_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      advance,
	input  wire debounce_t status,
	output gesture_t       gesture
);

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_UP    = 2'd1;
	localparam logic [1:0] PH_DOWN  = 2'd2;
	localparam logic [1:0] PH_DRAIN = 2'd3;

	logic [1:0] phase_q;
	logic [1:0] phase_next;

	always_comb begin
		phase_next = phase_q;
		gesture    = GEST_NONE;
		unique case (phase_q)
			PH_IDLE: begin
				if (status.settled) begin
					if (status.combo == COMBO_ALL) begin
						phase_next = PH_DRAIN;
						gesture    = GEST_TOGGLE;
					end else if (status.combo == COMBO_AB) begin
						phase_next = PH_UP;
						gesture    = GEST_UP;
					end else if (status.combo == COMBO_BC) begin
						phase_next = PH_DOWN;
						gesture    = GEST_DOWN;
					end
				end
			end
			PH_UP: begin
				if (status.combo == COMBO_AB) begin
					gesture = GEST_UP;
				end else begin
					phase_next = PH_DRAIN;
				end
			end
			PH_DOWN: begin
				if (status.combo == COMBO_BC) begin
					gesture = GEST_DOWN;
				end else begin
					phase_next = PH_DRAIN;
				end
			end
			PH_DRAIN: begin
				if (status.combo == COMBO_NONE && status.settled) begin
					phase_next = PH_IDLE;
				end
			end
			default: begin
				phase_next = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (advance) begin
			phase_q <= phase_next;
		end
	end

endmodule

`default_nettype wire

### hdl/touch_gesture_debounce_fsm.sv
// Top level of the touch gesture debouncer: poll register, tracker, phase machine.
// Depends on tgd_pkg, tgd_ifs, tgd_debounce and tgd_phase_fsm.
//
// Usage:
//   poll   - sink channel; each word is one 12-bit electrode bitmap (A, B, C on
//            bits 0, 2, 4, other bits ignored).
//   result - source channel; exactly one 2-bit gesture word per poll word, in order.
//   cfg_we / cfg_wdata - write stable_polls; write only while no poll is in flight.
// Path: the poll word is held in the poll register, and its gesture word is then
//   registered in the result register and presented on result.
// Throughput: one poll per cycle while result is not stalled; the poll and result
//   registers form a two-stage pipeline with a single debounce/phase pass between them.
// Stall: when result is not taken, the result register holds, the poll register
//   holds its word, and poll.ready drops only once both stages are full.
// Reset: stable_polls returns to 3, last combination to none, count to zero,
//   phase to idle, both pipeline stages empty.
`default_nettype none

module touch_gesture_debounce_fsm import tgd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	tgd_poll_if.sink                poll,
	tgd_result_if.source            result,
	input  wire logic               cfg_we,
	input  wire logic [POLLS_W-1:0] cfg_wdata
);

	logic [POLLS_W-1:0] stable_polls_q;

	logic      valid_s1;
	combo_t    combo_s1;
	logic      valid_s2;
	gesture_t  gesture_s2;

	logic      advance;
	logic      fire_s1;
	debounce_t status;
	gesture_t  gesture_next;

	// Advance the pipeline whenever the result register is empty or being drained.
	assign advance    = !valid_s2 || result.ready;
	assign poll.ready = !valid_s1 || advance;
	assign fire_s1    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_polls_q <= STABLE_POLLS_RESET;
		end else if (cfg_we) begin
			stable_polls_q <= cfg_wdata;
		end
	end

	// Stage 1: classify on entry, hold the combination.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			combo_s1 <= combo_of(poll.touched_bits);
		end
	end

	// State updates only when the stage-1 word moves into the result register.
	tgd_debounce u_debounce (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (fire_s1),
		.combo        (combo_s1),
		.stable_polls (stable_polls_q),
		.status       (status)
	);

	tgd_phase_fsm u_phase (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (fire_s1),
		.status  (status),
		.gesture (gesture_next)
	);

	// Stage 2: result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			gesture_s2 <= gesture_next;
		end
	end

	assign result.valid   = valid_s2;
	assign result.gesture = gesture_s2;

endmodule

`default_nettype wire

### tb/tb_touch_gesture_debounce_fsm.sv
// Self-checking testbench for touch_gesture_debounce_fsm: polls in, gesture words out.
// Depends on tgd_pkg and the channel interfaces in tgd_ifs; predicts every gesture
// word and compares it, in order, with what the block hands out.
`timescale 1ns / 100ps

module tb_touch_gesture_debounce_fsm;
	import tgd_pkg::*;

	typedef enum logic [1:0] {
		PHASE_IDLE,
		PHASE_RAMP_UP,
		PHASE_RAMP_DOWN,
		PHASE_DRAIN
	} phase_e;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [POLLS_W-1:0] cfg_wdata;

	tgd_poll_if   poll_ch ();
	tgd_result_if result_ch ();

	touch_gesture_debounce_fsm dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.poll      (poll_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Predicted state of the block, kept in step with every accepted poll word.
	logic [POLLS_W-1:0] model_polls;
	combo_t             model_combo;
	logic [POLLS_W-1:0] model_count;
	phase_e             model_phase;

	// Gesture words predicted but not yet seen on the result channel, oldest first.
	gesture_t pending_gestures[$];
	gesture_t oldest_gesture;
	int       mismatch_count;

	// Sender burst shaping; no_gaps forces back-to-back words.
	int burst_left;
	bit no_gaps;

	// Receiver stall pattern and long hold-off requests.
	int rx_mode;
	int rx_mode_left;
	int rx_cycle;
	int hold_request;
	int hold_seen;
	int hold_len;
	int hold_left;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// Classify the three electrodes; every other bit of the word is ignored.
	function automatic combo_t electrode_combo(input logic [TOUCH_W-1:0] bits);
		logic [2:0] abc;
		abc = {bits[ELECTRODE_A], bits[ELECTRODE_B], bits[ELECTRODE_C]};
		case (abc)
			3'b111: return COMBO_ALL;
			3'b110: return COMBO_AB;
			3'b011: return COMBO_BC;
			3'b000: return COMBO_NONE;
			default: return COMBO_OTHER;
		endcase
	endfunction

	// Advance the predicted state by one poll word and return its gesture.
	function automatic gesture_t next_gesture(input logic [TOUCH_W-1:0] bits);
		combo_t   c;
		logic     settled;
		gesture_t g;
		c = electrode_combo(bits);
		g = GEST_NONE;
		if (c == model_combo) begin
			if (model_count < model_polls)
				model_count = model_count + 1'b1;
		end else begin
			model_combo = c;
			model_count = 8'd1;
		end
		settled = (model_count >= model_polls);
		case (model_phase)
			PHASE_IDLE: begin
				if (settled) begin
					if (c == COMBO_ALL) begin
						model_phase = PHASE_DRAIN;
						g = GEST_TOGGLE;
					end else if (c == COMBO_AB) begin
						model_phase = PHASE_RAMP_UP;
						g = GEST_UP;
					end else if (c == COMBO_BC) begin
						model_phase = PHASE_RAMP_DOWN;
						g = GEST_DOWN;
					end
				end
			end
			// Ramps follow the raw combination, not the settled one.
			PHASE_RAMP_UP: begin
				if (c == COMBO_AB)
					g = GEST_UP;
				else
					model_phase = PHASE_DRAIN;
			end
			PHASE_RAMP_DOWN: begin
				if (c == COMBO_BC)
					g = GEST_DOWN;
				else
					model_phase = PHASE_DRAIN;
			end
			default: begin
				// Leave draining only on a settled release.
				if (c == COMBO_NONE && settled)
					model_phase = PHASE_IDLE;
			end
		endcase
		return g;
	endfunction

	// Build a poll word for a combination with random bits everywhere else.
	function automatic logic [TOUCH_W-1:0] touch_word(input combo_t c);
		logic [TOUCH_W-1:0] w;
		logic [2:0]         abc;
		w = TOUCH_W'($urandom);
		case (c)
			COMBO_NONE: abc = 3'b000;
			COMBO_AB:   abc = 3'b110;
			COMBO_BC:   abc = 3'b011;
			COMBO_ALL:  abc = 3'b111;
			default: begin
				case ($urandom_range(0, 3))
					0: abc = 3'b100;
					1: abc = 3'b010;
					2: abc = 3'b001;
					default: abc = 3'b101;
				endcase
			end
		endcase
		w[ELECTRODE_A] = abc[2];
		w[ELECTRODE_B] = abc[1];
		w[ELECTRODE_C] = abc[0];
		return w;
	endfunction

	// Offer one poll word, hold it until taken, then predict its gesture.
	// Enter and leave on a rising edge; valid stays high into the next word.
	task automatic send_poll(input logic [TOUCH_W-1:0] bits);
		int gap;
		if (!no_gaps && burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				poll_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		poll_ch.valid        <= 1'b1;
		poll_ch.touched_bits <= bits;
		do
			@(posedge clk);
		while (!poll_ch.ready);
		pending_gestures.push_back(next_gesture(bits));
	endtask

	// Drop valid and wait for every predicted word, then let the pipeline empty.
	task automatic drain_gestures();
		int waited;
		poll_ch.valid <= 1'b0;
		waited = 0;
		while (pending_gestures.size() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_gestures.size() != 0) begin
			report_mismatch($sformatf("%0d gesture words never arrived",
				pending_gestures.size()));
			pending_gestures.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_stable_polls(input logic [POLLS_W-1:0] value);
		drain_gestures();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		model_polls = value;
	endtask

	task automatic send_run(input combo_t c, input int count);
		repeat (count) send_poll(touch_word(c));
	endtask

	// Walk every gesture path at the reset debounce depth of three.
	task automatic test_reset_gestures();
		repeat (3) send_poll(12'h000);
		send_poll(12'h005);
		send_poll(12'h005);
		send_poll(12'hFE5);     // settled A+B with upper bits set: ramp up
		send_poll(12'h005);     // repeat ramp up
		send_poll(12'h001);     // A alone leaves the ramp
		send_poll(12'h000);
		send_poll(12'h000);
		send_poll(12'h000);     // settled release: back to idle
		send_poll(12'h014);
		send_poll(12'h014);
		send_poll(12'hA34);     // settled B+C: ramp down
		send_poll(12'h015);     // all three leaves the ramp
		send_poll(12'h000);
		send_poll(12'h000);
		send_poll(12'h000);
		send_poll(12'hFFF);
		send_poll(12'hFFF);
		send_poll(12'hFFF);     // settled all three: toggle
		send_poll(12'hFFF);     // draining ignores it
		send_poll(12'h010);
		send_poll(12'h011);
		send_poll(12'h004);
		send_poll(12'hFEA);
	endtask

	// Shallow debounce depths: one poll, and zero where everything is settled at once.
	task automatic test_shallow_debounce();
		write_stable_polls(8'd1);
		send_run(COMBO_AB, 2);
		send_run(COMBO_OTHER, 1);
		send_run(COMBO_NONE, 1);
		send_run(COMBO_ALL, 2);
		send_run(COMBO_NONE, 1);
		send_run(COMBO_BC, 3);
		send_run(COMBO_NONE, 2);
		write_stable_polls(8'd0);
		send_run(COMBO_BC, 2);
		send_run(COMBO_NONE, 1);
		send_run(COMBO_ALL, 1);
		send_run(COMBO_OTHER, 2);
		send_run(COMBO_NONE, 2);
		send_run(COMBO_AB, 3);
		send_run(COMBO_NONE, 1);
	endtask

	// Deepest debounce: the count has to climb all the way and saturate.
	task automatic test_deep_debounce();
		write_stable_polls(8'd255);
		send_run(COMBO_NONE, 4);
		send_run(COMBO_AB, 257);
		send_run(COMBO_OTHER, 1);
		send_run(COMBO_NONE, 256);
		send_run(COMBO_ALL, 2);
	endtask

	// Hold off the receiver for a long stretch while words keep coming back to back.
	task automatic test_result_backpressure();
		write_stable_polls(8'd2);
		hold_len     <= 80;
		hold_request <= hold_request + 1;
		no_gaps = 1'b1;
		send_run(COMBO_NONE, 2);
		send_run(COMBO_AB, 6);
		send_run(COMBO_OTHER, 2);
		send_run(COMBO_NONE, 3);
		send_run(COMBO_BC, 5);
		send_run(COMBO_NONE, 3);
		no_gaps = 1'b0;
	endtask

	// Mostly held combinations of random length, with some raw noise between them.
	task automatic test_random_gestures();
		int     sent;
		int     run_len;
		int     pick;
		combo_t c;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: write_stable_polls(8'd1);
				1: write_stable_polls(8'd2);
				2: write_stable_polls(8'd3);
				3: write_stable_polls(8'd0);
				4: write_stable_polls(8'd4);
				default: write_stable_polls(POLLS_W'($urandom_range(1, 6)));
			endcase
			no_gaps = (p == 2);
			sent = 0;
			while (sent < 105) begin
				if ($urandom_range(0, 4) == 0) begin
					run_len = $urandom_range(1, 3);
					repeat (run_len) send_poll(TOUCH_W'($urandom));
				end else begin
					pick = $urandom_range(0, 9);
					if (pick < 3)
						c = COMBO_NONE;
					else if (pick < 5)
						c = COMBO_AB;
					else if (pick < 7)
						c = COMBO_BC;
					else if (pick < 8)
						c = COMBO_ALL;
					else
						c = COMBO_OTHER;
					run_len = $urandom_range(1, model_polls + 4);
					send_run(c, run_len);
				end
				sent += run_len;
			end
		end
		no_gaps = 1'b0;
	endtask

	// Receiver: cycle through stall styles; a hold-off request overrides them all.
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_mode_left == 0) begin
			rx_mode      = $urandom_range(0, 3);
			rx_mode_left = $urandom_range(30, 300);
		end else begin
			rx_mode_left--;
		end
		if (hold_request != hold_seen) begin
			hold_seen = hold_request;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: result_ch.ready <= 1'b1;
				1: result_ch.ready <= 1'($urandom_range(0, 1));
				2: result_ch.ready <= ((rx_cycle % 7) >= 3);
				default: result_ch.ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	// Check each gesture word taken from the block against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_gestures.size() == 0) begin
				report_mismatch($sformatf("gesture word %0d with nothing predicted",
					result_ch.gesture));
			end else begin
				oldest_gesture = pending_gestures.pop_front();
				if (result_ch.gesture !== oldest_gesture)
					report_mismatch($sformatf("gesture %0d, predicted %0d",
						result_ch.gesture, oldest_gesture));
			end
		end
	end

	initial begin
		clk                  = 1'b0;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		poll_ch.valid        = 1'b0;
		poll_ch.touched_bits = '0;
		result_ch.ready      = 1'b0;
		mismatch_count       = 0;
		burst_left           = 0;
		no_gaps              = 1'b0;
		rx_mode              = 0;
		rx_mode_left         = 0;
		rx_cycle             = 0;
		hold_request         = 0;
		hold_seen            = 0;
		hold_len             = 0;
		hold_left            = 0;
		model_polls          = STABLE_POLLS_RESET;
		model_combo          = COMBO_NONE;
		model_count          = '0;
		model_phase          = PHASE_IDLE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_gestures();
		test_shallow_debounce();
		test_deep_debounce();
		test_result_backpressure();
		test_random_gestures();
		drain_gestures();

		if (mismatch_count == 0) begin
			$display("touch_gesture_debounce_fsm test passed");
		end else begin
			$display("touch_gesture_debounce_fsm test failed");
		end
		$finish;
	end

	// Stop a hung run; a correct one ends well inside this.
	initial begin
		#(5_000_000);
		$display("touch_gesture_debounce_fsm test failed");
		$finish;
	end

endmodule
